// ===== rtl/cht_pkg.sv =====
// Shared types, constants and codes for the cuckoo hash table.
package cht_pkg;

  localparam int unsigned KeyW = 31;
  localparam int unsigned LimitW = 18;
  localparam int unsigned KindW = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned TABLE_SIZE = 1024;
  localparam logic [LimitW-1:0] MAX_DISP_RESET = LimitW'(2048);

  typedef enum logic [KindW-1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_DELETE = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STS_INSERTED    = 3'd0,
    STS_DUPLICATE   = 3'd1,
    STS_FAILED      = 3'd2,
    STS_FOUND       = 3'd3,
    STS_NOT_FOUND   = 3'd4,
    STS_DELETED     = 3'd5,
    STS_DEL_MISSING = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_DECIDE,
    ST_REPROBE,
    ST_PLACE
  } state_e;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [KeyW-1:0]  key;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [KeyW-1:0]   dropped_key;
    logic [LimitW-1:0] displacement_count;
  } out_item_t;

  typedef struct packed {
    logic    clear;
    logic    load_item;
    logic    hash_start;
    logic    read_en;
    logic    wr_one;
    logic    wr_two;
    logic    wr_cur;
    logic    wr_valid;
    logic    evict;
    logic    res_load;
    status_e res_status;
    logic    res_evict;
  } cmd_t;

  typedef struct packed {
    logic             hash_done;
    logic             hit_one;
    logic             hit_two;
    logic             cur_valid;
    logic             at_limit;
    logic             zero_limit;
    logic             out_free;
    logic             clear_last;
    logic [KindW-1:0] kind;
  } sts_t;

endpackage

// ===== rtl/cht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cht_ram #(
  parameter int unsigned Width = cht_pkg::KeyW + 1,
  parameter int unsigned Depth = cht_pkg::TABLE_SIZE
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cht_hash.sv =====
// Slot computation: key mod size and (key / size) mod size.
module cht_hash #(
  parameter int unsigned TableSize = cht_pkg::TABLE_SIZE
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [cht_pkg::KeyW-1:0]     key_i,
  output logic                         done_o,
  output logic [$clog2(TableSize)-1:0] slot_one_o,
  output logic [$clog2(TableSize)-1:0] slot_two_o
);

  localparam int unsigned SlotW = $clog2(TableSize);

  if ((TableSize & (TableSize - 1)) == 0) begin : g_pow2
    logic [cht_pkg::KeyW-1:0] key_shift;

    assign key_shift  = key_i >> SlotW;
    assign slot_one_o = key_i[SlotW-1:0];
    assign slot_two_o = key_shift[SlotW-1:0];
    assign done_o     = start_i;
  end else begin : g_recip
    localparam int unsigned KeyW = cht_pkg::KeyW;
    localparam int unsigned ShiftS = KeyW + SlotW;
    localparam int unsigned ProdW = KeyW + 32;
    localparam logic [63:0] RecipWide = ((64'd1 << ShiftS) / 64'(TableSize)) + 64'd1;
    localparam logic [31:0] Recip = RecipWide[31:0];
    localparam logic [KeyW-1:0] SizeK = KeyW'(TableSize);

    logic             busy_q;
    logic             done_q;
    logic             step_q;
    logic [KeyW-1:0]  quo_q;
    logic [KeyW-1:0]  quo2_q;
    logic [SlotW-1:0] r1_q;
    logic [SlotW-1:0] r2_q;
    logic [ProdW-1:0] prod_key, prod_quo;
    logic [ProdW-1:0] sh_key, sh_quo;
    logic [KeyW-1:0]  rem_key, rem_quo;

    assign prod_key = ProdW'(key_i) * ProdW'(Recip);
    assign prod_quo = ProdW'(quo_q) * ProdW'(Recip);
    assign sh_key   = prod_key >> ShiftS;
    assign sh_quo   = prod_quo >> ShiftS;
    assign rem_key  = key_i - quo_q * SizeK;
    assign rem_quo  = quo_q - quo2_q * SizeK;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        done_q <= 1'b0;
        step_q <= 1'b0;
      end else begin
        done_q <= 1'b0;
        if (busy_q) begin
          step_q <= 1'b1;
          if (step_q) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end else if (start_i && !done_q) begin
          busy_q <= 1'b1;
          step_q <= 1'b0;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (busy_q) begin
        if (step_q) begin
          r2_q <= rem_quo[SlotW-1:0];
        end else begin
          quo2_q <= sh_quo[KeyW-1:0];
          r1_q   <= rem_key[SlotW-1:0];
        end
      end else if (start_i && !done_q) begin
        quo_q <= sh_key[KeyW-1:0];
      end
    end

    assign done_o     = done_q;
    assign slot_one_o = r1_q;
    assign slot_two_o = r2_q;
  end

endmodule

// ===== rtl/cht_ctrl.sv =====
// Controller state machine for lookup, delete and cuckoo placement.
module cht_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cht_pkg::sts_t sts_i,
  output cht_pkg::cmd_t cmd_o
);

  cht_pkg::state_e state_q, state_d;
  logic            dup;
  logic            placing;
  logic            res_now;
  logic            go;

  always_comb begin
    dup     = sts_i.hit_one | sts_i.hit_two;
    placing = 1'b0;
    res_now = 1'b0;
    case (state_q)
      cht_pkg::ST_DECIDE: begin
        placing = (sts_i.kind == cht_pkg::KIND_INSERT) && !dup && !sts_i.zero_limit;
        res_now = !placing || !sts_i.cur_valid || sts_i.at_limit;
      end
      cht_pkg::ST_PLACE: begin
        placing = 1'b1;
        res_now = !sts_i.cur_valid || sts_i.at_limit;
      end
      default: begin
        placing = 1'b0;
        res_now = 1'b0;
      end
    endcase
    go = !res_now || sts_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cht_pkg::ST_CLEAR: begin
        if (sts_i.clear_last) state_d = cht_pkg::ST_IDLE;
      end
      cht_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = cht_pkg::ST_PROBE;
      end
      cht_pkg::ST_PROBE: begin
        if (sts_i.hash_done) state_d = cht_pkg::ST_DECIDE;
      end
      cht_pkg::ST_REPROBE: begin
        if (sts_i.hash_done) state_d = cht_pkg::ST_PLACE;
      end
      cht_pkg::ST_DECIDE, cht_pkg::ST_PLACE: begin
        if (go) begin
          if (placing && sts_i.cur_valid && !sts_i.at_limit) begin
            state_d = cht_pkg::ST_REPROBE;
          end else begin
            state_d = cht_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = cht_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      cht_pkg::ST_CLEAR: begin
        cmd_o.clear  = 1'b1;
        cmd_o.wr_one = 1'b1;
        cmd_o.wr_two = 1'b1;
      end
      cht_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      cht_pkg::ST_PROBE, cht_pkg::ST_REPROBE: begin
        cmd_o.hash_start = 1'b1;
        cmd_o.read_en    = sts_i.hash_done;
      end
      cht_pkg::ST_DECIDE, cht_pkg::ST_PLACE: begin
        if (go) begin
          if (placing) begin
            cmd_o.wr_cur   = 1'b1;
            cmd_o.wr_valid = 1'b1;
            if (!sts_i.cur_valid) begin
              cmd_o.res_load   = 1'b1;
              cmd_o.res_status = cht_pkg::STS_INSERTED;
            end else begin
              cmd_o.evict = 1'b1;
              if (sts_i.at_limit) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = cht_pkg::STS_FAILED;
                cmd_o.res_evict  = 1'b1;
              end
            end
          end else begin
            cmd_o.res_load = 1'b1;
            case (sts_i.kind)
              cht_pkg::KIND_INSERT: begin
                cmd_o.res_status = dup ? cht_pkg::STS_DUPLICATE : cht_pkg::STS_FAILED;
              end
              cht_pkg::KIND_DELETE: begin
                if (sts_i.hit_one) begin
                  cmd_o.wr_one     = 1'b1;
                  cmd_o.res_status = cht_pkg::STS_DELETED;
                end else if (sts_i.hit_two) begin
                  cmd_o.wr_two     = 1'b1;
                  cmd_o.res_status = cht_pkg::STS_DELETED;
                end else begin
                  cmd_o.res_status = cht_pkg::STS_DEL_MISSING;
                end
              end
              default: begin
                cmd_o.res_status = dup ? cht_pkg::STS_FOUND : cht_pkg::STS_NOT_FOUND;
              end
            endcase
          end
        end
      end
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cht_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/cht_datapath.sv =====
// Datapath: item registers, hash unit, both key tables and the result register.
module cht_datapath #(
  parameter int unsigned TableSize = cht_pkg::TABLE_SIZE
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cht_pkg::in_item_t            in_data_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [cht_pkg::LimitW-1:0]   cfg_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output cht_pkg::out_item_t           out_data_o,
  input  cht_pkg::cmd_t                cmd_i,
  output cht_pkg::sts_t                sts_o
);

  localparam int unsigned SlotW = $clog2(TableSize);
  localparam int unsigned KeyW = cht_pkg::KeyW;
  localparam int unsigned LimitW = cht_pkg::LimitW;
  localparam int unsigned WordW = KeyW + 1;

  logic [cht_pkg::KindW-1:0] kind_q;
  logic [KeyW-1:0]           key_q;
  logic [KeyW-1:0]           hand_q;
  logic                      use_one_q;
  logic [LimitW-1:0]         moves_q;
  logic [LimitW-1:0]         moves_p1;
  logic [LimitW-1:0]         max_q;
  logic [SlotW-1:0]          s1_q, s2_q;
  logic [SlotW-1:0]          clear_idx_q;
  logic                      out_valid_q;
  cht_pkg::out_item_t        out_data_q;

  logic             hash_done;
  logic [SlotW-1:0] hash_s1, hash_s2;
  logic             we1, we2;
  logic [SlotW-1:0] waddr1, waddr2;
  logic [WordW-1:0] wdata;
  logic [WordW-1:0] rd1, rd2, cur;
  logic             out_free;

  cht_hash #(
    .TableSize(TableSize)
  ) u_hash (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.hash_start),
    .key_i      (hand_q),
    .done_o     (hash_done),
    .slot_one_o (hash_s1),
    .slot_two_o (hash_s2)
  );

  assign we1    = cmd_i.wr_one | (cmd_i.wr_cur & use_one_q);
  assign we2    = cmd_i.wr_two | (cmd_i.wr_cur & !use_one_q);
  assign waddr1 = cmd_i.clear ? clear_idx_q : s1_q;
  assign waddr2 = cmd_i.clear ? clear_idx_q : s2_q;
  assign wdata  = {cmd_i.wr_valid, hand_q};

  cht_ram #(
    .Width (WordW),
    .Depth (TableSize)
  ) u_ram_one (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (waddr1),
    .wdata_i (wdata),
    .re_i    (cmd_i.read_en),
    .raddr_i (hash_s1),
    .rdata_o (rd1)
  );

  cht_ram #(
    .Width (WordW),
    .Depth (TableSize)
  ) u_ram_two (
    .clk_i   (clk_i),
    .we_i    (we2),
    .waddr_i (waddr2),
    .wdata_i (wdata),
    .re_i    (cmd_i.read_en),
    .raddr_i (hash_s2),
    .rdata_o (rd2)
  );

  assign cur      = use_one_q ? rd1 : rd2;
  assign moves_p1 = moves_q + LimitW'(1);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o            = '0;
    sts_o.hash_done  = hash_done;
    sts_o.hit_one    = rd1[KeyW] && (rd1[KeyW-1:0] == key_q);
    sts_o.hit_two    = rd2[KeyW] && (rd2[KeyW-1:0] == key_q);
    sts_o.cur_valid  = cur[KeyW];
    sts_o.at_limit   = (moves_p1 == max_q);
    sts_o.zero_limit = (max_q == '0);
    sts_o.out_free   = out_free;
    sts_o.clear_last = (clear_idx_q == SlotW'(TableSize - 1));
    sts_o.kind       = kind_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= cht_pkg::MAX_DISP_RESET;
      clear_idx_q <= '0;
      out_valid_q <= 1'b0;
      use_one_q   <= 1'b1;
      moves_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        max_q <= cfg_data_i;
      end
      if (cmd_i.clear) begin
        clear_idx_q <= clear_idx_q + 1'b1;
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load_item) begin
        use_one_q <= 1'b1;
        moves_q   <= '0;
      end else if (cmd_i.evict) begin
        use_one_q <= !use_one_q;
        moves_q   <= moves_p1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q <= in_data_i.kind;
      key_q  <= in_data_i.key;
      hand_q <= in_data_i.key;
    end else if (cmd_i.evict) begin
      hand_q <= cur[KeyW-1:0];
    end
    if (cmd_i.read_en) begin
      s1_q <= hash_s1;
      s2_q <= hash_s2;
    end
    if (cmd_i.res_load) begin
      out_data_q.status             <= cmd_i.res_status;
      out_data_q.displacement_count <= cmd_i.res_evict ? moves_p1 : moves_q;
      if (cmd_i.res_status == cht_pkg::STS_FAILED) begin
        out_data_q.dropped_key <= cmd_i.res_evict ? cur[KeyW-1:0] : hand_q;
      end else begin
        out_data_q.dropped_key <= '0;
      end
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/cuckoo_hash_table.sv =====
// Top level of the two-table cuckoo hash set.
//
//   channel | direction | payload                                  | handshake
//   in      | in        | in_item_t: kind, key                     | in_valid_i / in_ready_o
//   out     | out       | out_item_t: status, dropped_key, count   | out_valid_o / out_ready_i
//   cfg     | in        | max_displacements (18 bits)              | cfg_valid_i / cfg_ready_o
//
// Search, delete and a duplicate insert pass idle, probe and decide when TableSize is a power of two;
// each eviction adds a rehash-and-read state, then a place state. For other sizes the slots
// come from a registered reciprocal divider instead of being taken straight from key bits.
// After reset a clearing pass writes every slot of both tables empty; no input is taken meanwhile.
// A finished result waits in the output register; the next transaction is accepted meanwhile
// and the block holds its final step until the output register is free.
module cuckoo_hash_table #(
  parameter int unsigned TableSize = cht_pkg::TABLE_SIZE
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  cht_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output cht_pkg::out_item_t         out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [cht_pkg::LimitW-1:0] cfg_data_i
);

  cht_pkg::cmd_t cmd;
  cht_pkg::sts_t sts;

  cht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cht_datapath #(
    .TableSize(TableSize)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
